FILE: design/ffha_pkg.sv
// Shared types and codes for the first-fit heap allocator.
`default_nettype none
package ffha_pkg;

	// request kinds
	localparam logic KIND_ALLOC = 1'b0;
	localparam logic KIND_FREE  = 1'b1;

	// result status codes
	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_NO_SPACE = 2'd1;
	localparam logic [1:0] ST_BAD_FREE = 2'd2;
	localparam logic [1:0] ST_ZERO     = 2'd3;

	// reciprocal shift for the bytes-to-words conversion
	localparam int RECIP_SHIFT = 20;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DIV,
		S_RDP,
		S_P,
		S_Q,
		S_FIT,
		S_SPLIT,
		S_FCHK,
		S_DONE
	} state_t;

endpackage
`default_nettype wire

FILE: design/ffha_ram.sv
// Generic single-port-write, single-port-read synchronous RAM with registered read.
`default_nettype none
module ffha_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write and registered read
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule
`default_nettype wire

FILE: design/ffha_hdr_store.sv
// Header word store: RAM plus the reset images of word 0 and the top sentinel.
`default_nettype none
module ffha_hdr_store #(
	parameter int ARENA_WORDS = 1024
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           rd_en,
	input  wire logic [$clog2(ARENA_WORDS)-1:0] rd_addr,
	output logic      [$clog2(ARENA_WORDS)-1:0] rd_next,
	output logic                                rd_busy,
	input  wire logic                           wr_en,
	input  wire logic [$clog2(ARENA_WORDS)-1:0] wr_addr,
	input  wire logic [$clog2(ARENA_WORDS)-1:0] wr_next,
	input  wire logic                           wr_busy
);

	localparam int IW = $clog2(ARENA_WORDS);
	localparam logic [IW-1:0] TOP = IW'(ARENA_WORDS - 1);

	logic [IW:0]   ram_rd;
	logic [IW-1:0] rd_addr_q;
	logic          w0_valid_q;

	ffha_ram #(.WIDTH(IW + 1), .DEPTH(ARENA_WORDS)) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data ({wr_next, wr_busy}),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (ram_rd)
	);

	// track the read address and whether word 0 has been written since reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w0_valid_q <= 1'b0;
			rd_addr_q  <= '0;
		end else begin
			if (rd_en) begin
				rd_addr_q <= rd_addr;
			end
			if (wr_en && wr_addr == '0) begin
				w0_valid_q <= 1'b1;
			end
		end
	end

	// substitute the fixed sentinel and the reset image of word 0
	always_comb begin
		if (rd_addr_q == TOP) begin
			rd_next = '0;
			rd_busy = 1'b1;
		end else if (rd_addr_q == '0 && !w0_valid_q) begin
			rd_next = TOP;
			rd_busy = 1'b0;
		end else begin
			rd_next = ram_rd[IW:1];
			rd_busy = ram_rd[0];
		end
	end

endmodule
`default_nettype wire

FILE: design/first_fit_heap_allocator.sv
// Top level of the first-fit heap allocator: request sequencer over the header store.
//
// Usage: raise start with kind, size_bytes and block_address while busy is low;
// the item is taken at that clock edge and busy rises in the next cycle.
// When the item is finished, done is high for exactly one cycle with
// result_address and status; the receiver has no way to hold it off and
// must take it in that cycle. busy is low again in the done cycle, so the
// next item may be started there; one item is in flight at a time.
// A zero-size allocate or a null free reads no header. An allocate visits the
// blocks from the rover, merges the free followers of each free block it
// visits and splits the block it takes if it is larger than the request; a
// free walks the chain from word 0 up to the freed block. Every header is
// read through the single read port of the header RAM.
// Reset: word 0 is one free block up to the top sentinel and the rover is 0;
// this image is held in logic, so there is no clearing pass after reset.
`default_nettype none
module first_fit_heap_allocator
	import ffha_pkg::*;
#(
	parameter int ARENA_WORDS = 1024,
	parameter int WORD_BYTES  = 2
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic        kind,
	input  wire logic [10:0] size_bytes,
	input  wire logic [9:0]  block_address,
	output logic             done,
	output logic      [9:0]  result_address,
	output logic      [1:0]  status
);

	localparam int IW = $clog2(ARENA_WORDS);
	localparam int CW = ((IW > 12) ? IW : 12) + 1;
	localparam logic [IW-1:0] TOP = IW'(ARENA_WORDS - 1);
	localparam int MW = RECIP_SHIFT + 1;
	localparam logic [MW-1:0] RECIP = MW'(((1 << RECIP_SHIFT) + WORD_BYTES - 1) / WORD_BYTES);
	localparam logic [11:0] ROUND = 12'(2 * WORD_BYTES - 1);

	state_t state_q, state_d;

	logic [IW-1:0] p_q, p_d, q_q, q_d, rover_q, rover_d;
	logic [11:0]   nw_q, nw_d;
	logic [10:0]   size_q, size_d;
	logic [CW-1:0] h_q, h_d;
	logic          lap_q, lap_d;
	logic          done_q, done_d;
	logic [9:0]    res_q, res_d;
	logic [1:0]    st_q, st_d;

	logic          rd_en, wr_en, wr_busy;
	logic [IW-1:0] rd_addr, wr_addr, wr_next, rd_next;
	logic          rd_busy;

	logic [11:0]     words_x;
	logic [12+MW-1:0] prod;
	logic [CW-1:0]   p_ext, q_ext, np_ext, nxt_ext;
	logic [IW-1:0]   np, nxt;

	ffha_hdr_store #(.ARENA_WORDS(ARENA_WORDS)) u_hdr (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_next (rd_next),
		.rd_busy (rd_busy),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_next (wr_next),
		.wr_busy (wr_busy)
	);

	// bytes to words with header, by reciprocal multiply
	assign words_x = {1'b0, size_q} + ROUND;
	assign prod    = (12+MW)'(words_x) * (12+MW)'(RECIP);

	assign p_ext  = CW'(p_q);
	assign q_ext  = CW'(q_q);
	assign np_ext = p_ext + CW'(nw_q);
	assign np     = np_ext[IW-1:0];

	// hold state and registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			rover_q <= '0;
			done_q  <= 1'b0;
			lap_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			rover_q <= rover_d;
			done_q  <= done_d;
			lap_q   <= lap_d;
		end
	end

	always_ff @(posedge clk) begin
		p_q    <= p_d;
		q_q    <= q_d;
		nw_q   <= nw_d;
		size_q <= size_d;
		h_q    <= h_d;
		res_q  <= res_d;
		st_q   <= st_d;
	end

	// sequence one item
	always_comb begin
		state_d = state_q;
		p_d     = p_q;
		q_d     = q_q;
		nw_d    = nw_q;
		size_d  = size_q;
		h_d     = h_q;
		lap_d   = lap_q;
		rover_d = rover_q;
		done_d  = 1'b0;
		res_d   = res_q;
		st_d    = st_q;
		rd_en   = 1'b0;
		rd_addr = p_q;
		wr_en   = 1'b0;
		wr_addr = p_q;
		wr_next = q_q;
		wr_busy = 1'b0;
		nxt     = q_q;
		nxt_ext = CW'(q_q);

		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					size_d = size_bytes;
					res_d  = '0;
					lap_d  = 1'b0;
					if (kind == KIND_ALLOC) begin
						if (size_bytes == '0) begin
							st_d    = ST_ZERO;
							state_d = S_DONE;
						end else begin
							state_d = S_DIV;
						end
					end else if (block_address == '0) begin
						st_d    = ST_OK;
						state_d = S_DONE;
					end else begin
						h_d     = CW'(block_address) - CW'(1);
						p_d     = '0;
						rd_en   = 1'b1;
						rd_addr = '0;
						state_d = S_FCHK;
					end
				end
			end

			S_DIV: begin
				nw_d    = prod[RECIP_SHIFT +: 12];
				p_d     = rover_q;
				state_d = S_RDP;
			end

			S_RDP: begin
				rd_en   = 1'b1;
				rd_addr = p_q;
				state_d = S_P;
			end

			S_P: begin
				q_d = rd_next;
				if (rd_busy) begin
					nxt     = rd_next;
					nxt_ext = CW'(rd_next);
					state_d = S_DONE;
				end else if (rd_next > p_q && rd_next < TOP) begin
					rd_en   = 1'b1;
					rd_addr = rd_next;
					state_d = S_Q;
				end else begin
					state_d = S_FIT;
				end
			end

			S_Q: begin
				// merge a free follower into p
				if (!rd_busy && rd_next > q_q) begin
					wr_en   = 1'b1;
					wr_addr = p_q;
					wr_next = rd_next;
					wr_busy = 1'b0;
					q_d     = rd_next;
					if (rd_next < TOP) begin
						rd_en   = 1'b1;
						rd_addr = rd_next;
					end else begin
						state_d = S_FIT;
					end
				end else begin
					state_d = S_FIT;
				end
			end

			S_FIT: begin
				if (q_q > p_q && q_ext >= np_ext) begin
					if (q_q > np) begin
						wr_en   = 1'b1;
						wr_addr = np;
						wr_next = q_q;
						wr_busy = 1'b0;
						state_d = S_SPLIT;
					end else begin
						wr_en   = 1'b1;
						wr_addr = p_q;
						wr_next = np;
						wr_busy = 1'b1;
						rover_d = np;
						st_d    = ST_OK;
						res_d   = 10'(p_ext + CW'(1));
						state_d = S_DONE;
					end
				end else begin
					nxt     = q_q;
					nxt_ext = CW'(q_q);
					state_d = S_DONE;
				end
			end

			S_SPLIT: begin
				wr_en   = 1'b1;
				wr_addr = p_q;
				wr_next = np;
				wr_busy = 1'b1;
				rover_d = np;
				st_d    = ST_OK;
				res_d   = 10'(p_ext + CW'(1));
				state_d = S_DONE;
			end

			S_FCHK: begin
				// walk the chain from word 0 to the freed header
				if (p_q == TOP || p_ext == h_q) begin
					st_d    = ST_BAD_FREE;
					state_d = S_DONE;
					if (p_ext == h_q && p_q != TOP && rd_busy) begin
						wr_en   = 1'b1;
						wr_addr = p_q;
						wr_next = rd_next;
						wr_busy = 1'b0;
						rover_d = p_q;
						st_d    = ST_OK;
					end
				end else if (rd_next <= p_q) begin
					st_d    = ST_BAD_FREE;
					state_d = S_DONE;
				end else begin
					p_d     = rd_next;
					rd_en   = 1'b1;
					rd_addr = rd_next;
				end
			end

			S_DONE: begin
				done_d  = 1'b1;
				state_d = S_IDLE;
			end

			default: begin
				state_d = S_IDLE;
			end
		endcase

		// advance the search to the next block, or give up
		if ((state_q == S_P && rd_busy) ||
		    (state_q == S_FIT && !(q_q > p_q && q_ext >= np_ext))) begin
			if (nxt_ext > p_ext) begin
				p_d     = nxt;
				state_d = S_RDP;
			end else if (p_q == TOP && nxt == '0 && !lap_q) begin
				lap_d   = 1'b1;
				p_d     = nxt;
				state_d = S_RDP;
			end else begin
				rover_d = '0;
				st_d    = ST_NO_SPACE;
				res_d   = '0;
				state_d = S_DONE;
			end
		end
	end

	assign busy           = (state_q != S_IDLE);
	assign done           = done_q;
	assign result_address = res_q;
	assign status         = st_q;

endmodule
`default_nettype wire

FILE: test/tb_first_fit_heap_allocator.sv
// Testbench for the first-fit heap allocator: directed table plus random alloc/free traffic.
`timescale 1ns / 1ps
module tb_first_fit_heap_allocator
	import ffha_pkg::*;
();

	localparam int ARENA = 1024;
	localparam int WBYTES = 2;
	localparam int TOPW = ARENA - 1;
	localparam int GUARD = 4 * ARENA + 8;
	localparam int N_RANDOM = 530;

	typedef struct {
		logic       kind;
		logic [10:0] size;
		logic [9:0] addr;
		logic       known;
		logic [9:0] exp_addr;
		logic [1:0] exp_status;
	} row_t;

	typedef struct {
		logic [9:0] addr;
		logic [1:0] status;
	} reply_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        kind = KIND_ALLOC;
	logic [10:0] size_bytes = '0;
	logic [9:0]  block_address = '0;
	wire         busy;
	wire         done;
	wire  [9:0]  result_address;
	wire  [1:0]  status;

	// arena shadow
	int unsigned heap_words [ARENA];
	int unsigned heap_rover;
	reply_t pending_replies [$];
	int unsigned live_blocks [$];
	int errors = 0;
	int n_items = 0;
	int n_ok = 0, n_nospace = 0, n_bad = 0, n_zero = 0;

	first_fit_heap_allocator u_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.kind(kind), .size_bytes(size_bytes), .block_address(block_address),
		.done(done), .result_address(result_address), .status(status)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	initial begin
		#300ms;
		$display("Test completed with failures");
		$finish;
	end

	function automatic int unsigned clip(int unsigned i);
		return (i < ARENA) ? i : TOPW;
	endfunction

	function automatic int unsigned link_of(int unsigned i);
		return clip(heap_words[clip(i)] >> 1);
	endfunction

	function automatic bit used_of(int unsigned i);
		return heap_words[clip(i)][0];
	endfunction

	function automatic void set_hdr(int unsigned i, int unsigned nxt, bit b);
		heap_words[clip(i)] = (clip(nxt) << 1) | b;
	endfunction

	function automatic void arena_reset();
		foreach (heap_words[i]) heap_words[i] = 0;
		set_hdr(0, TOPW, 1'b0);
		set_hdr(TOPW, 0, 1'b1);
		heap_rover = 0;
	endfunction

	function automatic reply_t predict_alloc(int unsigned sz);
		reply_t r;
		int unsigned nw, p, q, laps, steps, np;
		r.addr = '0;
		if (sz == 0) begin
			r.status = ST_ZERO;
			return r;
		end
		nw = (sz + 2 * WBYTES - 1) / WBYTES;
		p = clip(heap_rover);
		laps = 0;
		steps = 0;
		forever begin
			steps++;
			if (steps > GUARD) break;
			if (!used_of(p)) begin
				q = link_of(p);
				// merge following free blocks
				while (q > p && q < TOPW && !used_of(q) && link_of(q) > q) begin
					set_hdr(p, link_of(q), 1'b0);
					q = link_of(p);
				end
				if (q > p && q >= p + nw) begin
					np = p + nw;
					if (q > np) set_hdr(np, q, 1'b0);
					set_hdr(p, np, 1'b1);
					heap_rover = np;
					r.status = ST_OK;
					r.addr = 10'(p + 1);
					return r;
				end
			end
			q = p;
			p = link_of(p);
			if (p > q) continue;
			if (q != TOPW || p != 0) break;
			laps++;
			if (laps > 1) break;
		end
		heap_rover = 0;
		r.status = ST_NO_SPACE;
		return r;
	endfunction

	function automatic reply_t predict_free(int unsigned a);
		reply_t r;
		int unsigned h, b, n, steps;
		r.addr = '0;
		r.status = ST_OK;
		if (a == 0) return r;
		h = a - 1;
		b = 0;
		steps = 0;
		while (b != TOPW && b != h) begin
			n = link_of(b);
			steps++;
			if (n <= b || steps > GUARD) begin
				r.status = ST_BAD_FREE;
				return r;
			end
			b = n;
		end
		if (b != h || h == TOPW || !used_of(h)) begin
			r.status = ST_BAD_FREE;
			return r;
		end
		set_hdr(h, link_of(h), 1'b0);
		heap_rover = h;
		return r;
	endfunction

	// check each result against the oldest expectation
	always @(posedge clk) begin
		reply_t e;
		if (done) begin
			if (pending_replies.size() == 0) begin
				$error("result with no item outstanding: addr %0d status %0d",
					result_address, status);
				errors++;
			end else begin
				e = pending_replies.pop_front();
				if (result_address !== e.addr) begin
					$error("result_address: expected %0d, got %0d", e.addr, result_address);
					errors++;
				end
				if (status !== e.status) begin
					$error("status: expected %0d, got %0d", e.status, status);
					errors++;
				end
			end
		end
	end

	task automatic send_item(row_t it);
		reply_t r;
		int gap;
		bit taken;
		gap = $urandom_range(0, 8);
		if ($urandom_range(0, 3) == 0) gap = 0;
		// drop start while idling before the item
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		kind <= it.kind;
		size_bytes <= it.size;
		block_address <= it.addr;
		// predict in acceptance order
		if (it.kind == KIND_ALLOC) r = predict_alloc(32'(it.size));
		else r = predict_free(32'(it.addr));
		if (it.known && (r.addr !== it.exp_addr || r.status !== it.exp_status)) begin
			$error("table row disagrees with predictor: addr %0d status %0d", r.addr, r.status);
			errors++;
		end
		if (it.kind == KIND_ALLOC && r.status == ST_OK) live_blocks.push_back(32'(r.addr));
		case (r.status)
			ST_OK: n_ok++;
			ST_NO_SPACE: n_nospace++;
			ST_BAD_FREE: n_bad++;
			default: n_zero++;
		endcase
		pending_replies.push_back(r);
		n_items++;
		// hold the item until an edge with busy low takes it
		taken = 1'b0;
		while (!taken) begin
			@(negedge clk);
			taken = !busy;
			@(posedge clk);
		end
	endtask

	function automatic row_t mk(logic k, int unsigned sz, int unsigned a, logic kn,
		int unsigned ea, logic [1:0] es);
		row_t t;
		t.kind = k; t.size = 11'(sz); t.addr = 10'(a); t.known = kn;
		t.exp_addr = 10'(ea); t.exp_status = es;
		return t;
	endfunction

	initial begin
		row_t plan [$];
		row_t it;
		int idx, wait_cycles;
		arena_reset();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: first alloc after reset lands at word 1
		plan.push_back(mk(KIND_ALLOC, 1, 0, 1, 1, ST_OK));
		plan.push_back(mk(KIND_ALLOC, 0, 0, 1, 0, ST_ZERO));
		plan.push_back(mk(KIND_FREE, 0, 0, 1, 0, ST_OK));
		plan.push_back(mk(KIND_FREE, 2047, 1023, 1, 0, ST_BAD_FREE));
		plan.push_back(mk(KIND_FREE, 0, 5, 1, 0, ST_BAD_FREE));
		plan.push_back(mk(KIND_ALLOC, 2047, 1023, 1, 0, ST_NO_SPACE));
		plan.push_back(mk(KIND_ALLOC, 2, 0, 0, 0, ST_OK));
		plan.push_back(mk(KIND_ALLOC, 3, 0, 0, 0, ST_OK));
		plan.push_back(mk(KIND_FREE, 0, 1, 1, 0, ST_OK));
		plan.push_back(mk(KIND_FREE, 0, 1, 1, 0, ST_BAD_FREE));
		plan.push_back(mk(KIND_ALLOC, 1000, 0, 0, 0, ST_OK));
		plan.push_back(mk(KIND_ALLOC, 1000, 0, 0, 0, ST_OK));
		plan.push_back(mk(KIND_ALLOC, 2, 0, 0, 0, ST_OK));
		plan.push_back(mk(KIND_FREE, 0, 3, 0, 0, ST_OK));
		plan.push_back(mk(KIND_FREE, 0, 6, 0, 0, ST_OK));
		plan.push_back(mk(KIND_ALLOC, 6, 0, 0, 0, ST_OK));
		plan.push_back(mk(KIND_ALLOC, 1, 0, 0, 0, ST_OK));
		plan.push_back(mk(KIND_FREE, 0, 1022, 0, 0, ST_OK));
		plan.push_back(mk(KIND_ALLOC, 1024, 0, 0, 0, ST_OK));
		plan.push_back(mk(KIND_FREE, 1, 512, 0, 0, ST_OK));
		foreach (plan[i]) send_item(plan[i]);

		// random traffic: mostly frees of live blocks and small allocs
		repeat (N_RANDOM) begin
			case ($urandom_range(0, 9))
				0, 1, 2, 3: it = mk(KIND_ALLOC, $urandom_range(1, 60), $urandom, 0, 0, ST_OK);
				4: it = mk(KIND_ALLOC, $urandom_range(0, 2047), $urandom, 0, 0, ST_OK);
				5, 6, 7: begin
					if (live_blocks.size() > 0) begin
						idx = $urandom_range(0, live_blocks.size() - 1);
						it = mk(KIND_FREE, $urandom, live_blocks[idx], 0, 0, ST_OK);
						live_blocks.delete(idx);
					end else begin
						it = mk(KIND_FREE, $urandom, $urandom, 0, 0, ST_OK);
					end
				end
				default: it = mk(KIND_FREE, $urandom, $urandom_range(0, 1023), 0, 0, ST_OK);
			endcase
			send_item(it);
		end
		start <= 1'b0;

		// drain outstanding results
		wait_cycles = 0;
		while (pending_replies.size() > 0 && wait_cycles < 200000) begin
			@(posedge clk);
			wait_cycles++;
		end
		if (pending_replies.size() > 0) begin
			$error("%0d results never arrived", pending_replies.size());
			errors++;
		end
		repeat (50) @(posedge clk);
		$display("Ran %0d items: %0d ok, %0d no space, %0d bad free, %0d zero size.",
			n_items, n_ok, n_nospace, n_bad, n_zero);
		if (errors == 0) $display("Test completed successfully");
		else $display("Test completed with failures");
		$finish;
	end

endmodule

FILE: filelist.f
design/ffha_pkg.sv
design/ffha_ram.sv
design/ffha_hdr_store.sv
design/first_fit_heap_allocator.sv
test/tb_first_fit_heap_allocator.sv
